>>> rtl/pgf_pkg.sv
package pgf_pkg;

  localparam int MagW   = 33;
  localparam int SumW   = 66;
  localparam int RootW  = 33;
  localparam int KW     = 96;
  localparam int D3W    = 99;
  localparam int ProdW  = 129;
  localparam int QW     = 48;
  localparam int FLowW  = 24;
  localparam int PLowW  = 40;
  localparam int Axes   = 3;

  localparam logic [31:0] GravReset = 32'h0100_0000;
  localparam logic [QW-1:0] PotMax  = {QW{1'b1}};
  localparam logic [QW-1:0] PosMax  = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] NegMax  = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] this_pos_x;
    logic signed [31:0] this_pos_y;
    logic signed [31:0] this_pos_z;
    logic [31:0]        this_mass;
    logic signed [31:0] other_pos_x;
    logic signed [31:0] other_pos_y;
    logic signed [31:0] other_pos_z;
    logic [31:0]        other_mass;
  } in_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic signed [47:0] force_z;
    logic [47:0]        potential;
    logic               zero_distance;
    logic               overflow;
  } out_t;

  typedef struct packed {
    logic [Axes-1:0]           neg;
    logic [Axes-1:0][MagW-1:0] mag;
    logic                      zero;
  } geo_t;

  typedef struct packed {
    logic [Axes-1:0][D3W-1:0]   frem;
    logic [Axes-1:0][FLowW-1:0] flow;
    logic [Axes-1:0][QW-1:0]    fq;
    logic [Axes-1:0]            fovf;
    logic [D3W-1:0]             d3;
    logic [RootW-1:0]           prem;
    logic [PLowW-1:0]           plow;
    logic [QW-1:0]              pq;
    logic                       povf;
    logic [RootW-1:0]           root;
    logic [Axes-1:0]            neg;
    logic                       zero;
  } div_t;

endpackage

>>> rtl/pairwise_gravity_force_unit.sv
// Pairwise gravitational force unit.
// Input channel: drive item with start high; the word is taken at any rising
// edge where start is high and busy is low. busy stays low, so a new pair can
// be issued every cycle.
// Result channel: done pulses for one cycle with result valid in that cycle;
// done and result are driven from the output register. Results leave in issue
// order. The receiver takes every result in the cycle it appears.
// Throughput is one pair per cycle; a pair passes through four input stages,
// the 33-step square-root pipeline, four product stages, the 48-step quotient
// pipelines and the output register.
// Config channel: cfg_data is written to the gravitational constant (unsigned
// Q8.24) at an edge with cfg_valid and cfg_ready high; cfg_ready stays high.
// Write it only with no pair in flight.
// Reset (rst, synchronous) empties the pipeline, drops pairs in flight and
// sets the constant to 1.0.
module pairwise_gravity_force_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  pgf_pkg::in_t     item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [31:0]      cfg_data,
  output logic             done,
  output pgf_pkg::out_t    result
);
  import pgf_pkg::*;

  logic [31:0]      grav_const;
  logic             f_valid, s_valid, p_valid;
  logic [SumW-1:0]  f_sum;
  geo_t             f_geo, s_geo;
  logic [KW-1:0]    f_k, s_k;
  logic [RootW-1:0] s_root;
  div_t             p_work;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grav_const <= GravReset;
    end else if (cfg_valid && cfg_ready) begin
      grav_const <= cfg_data;
    end
  end

  pgf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .item      (item),
    .gconst    (grav_const),
    .out_valid (f_valid),
    .sum       (f_sum),
    .geo       (f_geo),
    .k         (f_k)
  );

  pgf_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .sum       (f_sum),
    .geo_i     (f_geo),
    .k_i       (f_k),
    .out_valid (s_valid),
    .root_o    (s_root),
    .geo_o     (s_geo),
    .k_o       (s_k)
  );

  pgf_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .root      (s_root),
    .geo       (s_geo),
    .k         (s_k),
    .out_valid (p_valid),
    .work      (p_work)
  );

  pgf_divide u_divide (
    .clk      (clk),
    .rst      (rst),
    .in_valid (p_valid),
    .work     (p_work),
    .done     (done),
    .result   (result)
  );

endmodule

>>> rtl/pgf_front.sv
module pgf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pgf_pkg::in_t        item,
  input  logic [31:0]         gconst,
  output logic                out_valid,
  output logic [65:0]         sum,
  output pgf_pkg::geo_t       geo,
  output logic [95:0]         k
);
  import pgf_pkg::*;

  logic [Axes-1:0][31:0]   tp, op;
  logic [Axes-1:0][MagW-1:0] dif;
  geo_t                    geo_n;

  logic        va, vb, vc, vd;
  geo_t        geo_a, geo_b, geo_c, geo_d;
  logic [31:0] ga, m1a, m2a, m2b;
  logic [SumW-1:0] sqb [Axes];
  logic [63:0] gm, pa, pb;
  logic [SumW-1:0] s_c, s_d;
  logic [KW-1:0] k_d;

  assign tp = {item.this_pos_z, item.this_pos_y, item.this_pos_x};
  assign op = {item.other_pos_z, item.other_pos_y, item.other_pos_x};

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      dif[i] = {tp[i][31], tp[i]} - {op[i][31], op[i]};
      geo_n.neg[i] = dif[i][MagW-1];
      geo_n.mag[i] = dif[i][MagW-1] ? (~dif[i] + 33'd1) : dif[i];
    end
    geo_n.zero = (dif[0] == '0) && (dif[1] == '0) && (dif[2] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
    end else begin
      va <= in_valid;
      vb <= va;
      vc <= vb;
      vd <= vc;
    end
  end

  always_ff @(posedge clk) begin
    geo_a <= geo_n;
    ga    <= gconst;
    m1a   <= item.this_mass;
    m2a   <= item.other_mass;

    for (int i = 0; i < Axes; i++) begin
      sqb[i] <= SumW'(geo_a.mag[i]) * SumW'(geo_a.mag[i]);
    end
    gm    <= 64'(ga) * 64'(m1a);
    m2b   <= m2a;
    geo_b <= geo_a;

    s_c   <= sqb[0] + sqb[1] + sqb[2];
    pa    <= 64'(gm[31:0]) * 64'(m2b);
    pb    <= 64'(gm[63:32]) * 64'(m2b);
    geo_c <= geo_b;

    s_d   <= s_c;
    k_d   <= {32'd0, pa} + {pb, 32'd0};
    geo_d <= geo_c;
  end

  assign out_valid = vd;
  assign sum       = s_d;
  assign geo       = geo_d;
  assign k         = k_d;

endmodule

>>> rtl/pgf_sqrt.sv
module pgf_sqrt (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [65:0]   sum,
  input  pgf_pkg::geo_t geo_i,
  input  logic [95:0]   k_i,
  output logic          out_valid,
  output logic [32:0]   root_o,
  output pgf_pkg::geo_t geo_o,
  output logic [95:0]   k_o
);
  import pgf_pkg::*;

  logic [RootW:0]   v;
  logic [SumW-1:0]  rem  [RootW+1];
  logic [RootW-1:0] root [RootW+1];
  geo_t             geo  [RootW+1];
  logic [KW-1:0]    kk   [RootW+1];

  assign v[0]    = in_valid;
  assign rem[0]  = sum;
  assign root[0] = '0;
  assign geo[0]  = geo_i;
  assign kk[0]   = k_i;

  for (genvar g = 0; g < RootW; g++) begin : g_step
    localparam int B = RootW - 1 - g;
    logic [67:0] trial;
    logic        take;

    assign trial = ({35'd0, root[g]} << (B + 1)) + (68'd1 << (2 * B));
    assign take  = {2'b00, rem[g]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      rem[g+1]  <= take ? (rem[g] - trial[SumW-1:0]) : rem[g];
      root[g+1] <= take ? (root[g] | (33'd1 << B)) : root[g];
      geo[g+1]  <= geo[g];
      kk[g+1]   <= kk[g];
    end
  end

  assign out_valid = v[RootW];
  assign root_o    = root[RootW];
  assign geo_o     = geo[RootW];
  assign k_o       = kk[RootW];

endmodule

>>> rtl/pgf_prep.sv
module pgf_prep (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [32:0]   root,
  input  pgf_pkg::geo_t geo,
  input  logic [95:0]   k,
  output logic          out_valid,
  output pgf_pkg::div_t work
);
  import pgf_pkg::*;

  logic             v1, v2, v3, v4;
  logic [RootW-1:0] d1, d2r, d3r;
  geo_t             g1, g2, g3;
  logic [KW-1:0]    k1, k2, k3;
  logic [SumW-1:0]  dsq;
  logic [64:0]      pp [Axes][3];
  logic [SumW-1:0]  cla, clb;
  logic [ProdW-1:0] p2 [Axes];
  logic [ProdW-1:0] p3 [Axes];
  logic [D3W-1:0]   cube;
  div_t             w4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    dsq <= SumW'(root) * SumW'(root);
    for (int i = 0; i < Axes; i++) begin
      for (int j = 0; j < 3; j++) begin
        pp[i][j] <= 65'(geo.mag[i]) * 65'(k[32*j +: 32]);
      end
    end
    d1 <= root;
    g1 <= geo;
    k1 <= k;

    cla <= SumW'(dsq[32:0]) * SumW'(d1);
    clb <= SumW'(dsq[65:33]) * SumW'(d1);
    for (int i = 0; i < Axes; i++) begin
      p2[i] <= {64'd0, pp[i][0]} + {32'd0, pp[i][1], 32'd0} + {pp[i][2], 64'd0};
    end
    d2r <= d1;
    g2  <= g1;
    k2  <= k1;

    cube <= {33'd0, cla} + {clb, 33'd0};
    for (int i = 0; i < Axes; i++) begin
      p3[i] <= p2[i];
    end
    d3r <= d2r;
    g3  <= g2;
    k3  <= k2;

    for (int i = 0; i < Axes; i++) begin
      w4.fovf[i] <= p3[i][128:24] >= {6'd0, cube};
      w4.frem[i] <= p3[i][122:24];
      w4.flow[i] <= p3[i][23:0];
    end
    w4.fq   <= '0;
    w4.d3   <= cube;
    w4.povf <= k3[95:40] >= {23'd0, d3r};
    w4.prem <= k3[72:40];
    w4.plow <= k3[39:0];
    w4.pq   <= '0;
    w4.root <= d3r;
    w4.neg  <= g3.neg;
    w4.zero <= g3.zero;
  end

  assign out_valid = v4;
  assign work      = w4;

endmodule

>>> rtl/pgf_divide.sv
module pgf_divide (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  pgf_pkg::div_t work,
  output logic          done,
  output pgf_pkg::out_t result
);
  import pgf_pkg::*;

  logic [QW:0] v;
  div_t        st [QW+1];
  out_t        res_n, res_q;
  logic        done_q;

  assign v[0]  = in_valid;
  assign st[0] = work;

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [D3W:0]   frem2 [Axes];
    logic [Axes-1:0] ftake;
    logic [RootW:0] prem2;
    logic           ptake;
    div_t           nx;

    always_comb begin
      nx = st[g];
      for (int i = 0; i < Axes; i++) begin
        frem2[i] = {st[g].frem[i], st[g].flow[i][FLowW-1]};
        ftake[i] = frem2[i] >= {1'b0, st[g].d3};
        nx.frem[i] = ftake[i] ? D3W'(frem2[i] - {1'b0, st[g].d3}) : frem2[i][D3W-1:0];
        nx.flow[i] = {st[g].flow[i][FLowW-2:0], 1'b0};
        nx.fq[i]   = {st[g].fq[i][QW-2:0], ftake[i]};
      end
      prem2   = {st[g].prem, st[g].plow[PLowW-1]};
      ptake   = prem2 >= {1'b0, st[g].root};
      nx.prem = ptake ? RootW'(prem2 - {1'b0, st[g].root}) : prem2[RootW-1:0];
      nx.plow = {st[g].plow[PLowW-2:0], 1'b0};
      nx.pq   = {st[g].pq[QW-2:0], ptake};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g+1] <= 1'b0;
      end else begin
        v[g+1] <= v[g];
      end
    end

    always_ff @(posedge clk) begin
      st[g+1] <= nx;
    end
  end

  logic [Axes-1:0][QW-1:0] fmag, lim, fout;
  logic [Axes-1:0]         fsat;
  logic                    psat;

  always_comb begin
    for (int i = 0; i < Axes; i++) begin
      lim[i]  = st[QW].neg[i] ? NegMax : PosMax;
      fsat[i] = st[QW].fovf[i] || (st[QW].fq[i] > lim[i]);
      fmag[i] = fsat[i] ? lim[i] : st[QW].fq[i];
      fout[i] = st[QW].neg[i] ? (~fmag[i] + 48'd1) : fmag[i];
    end
    psat = st[QW].povf;
    res_n.force_x       = fout[0];
    res_n.force_y       = fout[1];
    res_n.force_z       = fout[2];
    res_n.potential     = psat ? PotMax : st[QW].pq;
    res_n.zero_distance = 1'b0;
    res_n.overflow      = psat || (fsat != '0);
    if (st[QW].zero) begin
      res_n = '0;
      res_n.zero_distance = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v[QW];
    end
  end

  always_ff @(posedge clk) begin
    res_q <= res_n;
  end

  assign done   = done_q;
  assign result = res_q;

endmodule

>>> dv/pairwise_gravity_force_unit_tb.sv
`timescale 1ns / 1ps

module pairwise_gravity_force_unit_tb;
  import pgf_pkg::*;

  localparam int Latency   = 90;
  localparam int NumRandom = 1520;
  localparam int CycleLimit = 400000;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  in_t           item = '0;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [31:0]   cfg_data = '0;
  logic          done;
  out_t          result;

  in_t           pending_pairs[$];
  out_t          expected_forces[$];
  logic [31:0]   grav_model = GravReset;
  int            mismatches = 0;
  int            results_seen = 0;
  int            pairs_sent = 0;
  int            cycles = 0;
  bit            gaps_on = 1'b1;
  bit            hold_sender = 1'b0;
  int            gap_left = 0;

  pairwise_gravity_force_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .done(done), .result(result)
  );

  always #4 clk = ~clk;

  function automatic void queue_pair(in_t p);
    pending_pairs.insert(pending_pairs.size(), p);
  endfunction

  function automatic logic [33:0] isqrt(logic [65:0] s);
    logic [33:0] r;
    logic [33:0] c;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c = r | (34'd1 << b);
      if ({34'd0, c} * {34'd0, c} <= {2'd0, s}) r = c;
    end
    return r;
  endfunction

  function automatic out_t gravity_pair(in_t p, logic [31:0] g);
    out_t o;
    logic signed [32:0] diff[3];
    logic [32:0] mag[3];
    logic neg[3];
    logic [65:0] sum_sq;
    logic [33:0] root;
    logic [255:0] k, pq, d3, fq, lim;
    logic [47:0] m;
    o = '0;
    diff[0] = 33'(p.this_pos_x) - 33'(p.other_pos_x);
    diff[1] = 33'(p.this_pos_y) - 33'(p.other_pos_y);
    diff[2] = 33'(p.this_pos_z) - 33'(p.other_pos_z);
    sum_sq = '0;
    for (int a = 0; a < 3; a++) begin
      neg[a] = diff[a] < 0;
      mag[a] = neg[a] ? 33'(-diff[a]) : 33'(diff[a]);
      sum_sq += {33'd0, mag[a]} * {33'd0, mag[a]};
    end
    if (sum_sq == 0) begin
      o.zero_distance = 1'b1;
      return o;
    end
    root = isqrt(sum_sq);
    k = 256'(g) * 256'(p.this_mass) * 256'(p.other_mass);
    pq = (k << 8) / 256'(root);
    if (pq > 256'(PotMax)) begin
      o.potential = PotMax;
      o.overflow = 1'b1;
    end else o.potential = pq[47:0];
    d3 = 256'(root) * 256'(root) * 256'(root);
    for (int a = 0; a < 3; a++) begin
      fq = ((k << 24) * 256'(mag[a])) / d3;
      lim = neg[a] ? (256'd1 << 47) : ((256'd1 << 47) - 1);
      if (fq > lim) begin
        m = lim[47:0];
        o.overflow = 1'b1;
      end else m = fq[47:0];
      m = neg[a] ? -m : m;
      case (a)
        0: o.force_x = m;
        1: o.force_y = m;
        default: o.force_z = m;
      endcase
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      expected_forces.insert(expected_forces.size(), gravity_pair(item, grav_model));
      pairs_sent <= pairs_sent + 1;
      if (pending_pairs.size() > 0 && !hold_sender && gap_left == 0 &&
          !(gaps_on && $urandom_range(0, 15) == 0)) begin
        item <= pending_pairs.pop_front();
      end else begin
        start <= 1'b0;
        if (gaps_on && gap_left == 0 && $urandom_range(0, 1)) gap_left <= $urandom_range(1, 18);
      end
    end else if (!start) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() > 0 && !hold_sender) begin
        item <= pending_pairs.pop_front();
        start <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && done) begin
      results_seen <= results_seen + 1;
      if (expected_forces.size() == 0) begin
        report_mismatch("unexpected result", result.potential, '0);
      end else begin
        want = expected_forces.pop_front();
        if (result.force_x !== want.force_x)
          report_mismatch("force_x", result.force_x, want.force_x);
        if (result.force_y !== want.force_y)
          report_mismatch("force_y", result.force_y, want.force_y);
        if (result.force_z !== want.force_z)
          report_mismatch("force_z", result.force_z, want.force_z);
        if (result.potential !== want.potential)
          report_mismatch("potential", result.potential, want.potential);
        if (result.zero_distance !== want.zero_distance)
          report_mismatch("zero_distance", 48'(result.zero_distance),
                          48'(want.zero_distance));
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", 48'(result.overflow), 48'(want.overflow));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles >= CycleLimit) begin
      $display("timeout at cycle %0d", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8191)) - 4096) << 16;
      default: return 32'($signed($urandom_range(0, 511)) - 256);
    endcase
  endfunction

  function automatic in_t rand_pair();
    in_t p;
    int mode;
    mode = $urandom_range(0, 2);
    p.this_pos_x = rand_pos(mode);
    p.this_pos_y = rand_pos(mode);
    p.this_pos_z = rand_pos(mode);
    p.other_pos_x = rand_pos(mode);
    p.other_pos_y = rand_pos(mode);
    p.other_pos_z = rand_pos(mode);
    if ($urandom_range(0, 19) == 0) begin
      p.other_pos_x = p.this_pos_x;
      p.other_pos_y = p.this_pos_y;
      p.other_pos_z = p.this_pos_z;
    end else if ($urandom_range(0, 9) == 0) begin
      p.other_pos_x = p.this_pos_x + 32'($urandom_range(0, 2)) - 1;
    end
    case ($urandom_range(0, 3))
      0: p.this_mass = $urandom;
      1: p.this_mass = $urandom_range(0, 65535);
      default: p.this_mass = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 3))
      0: p.other_mass = $urandom;
      1: p.other_mass = $urandom_range(0, 65535);
      default: p.other_mass = $urandom_range(0, 255);
    endcase
    return p;
  endfunction

  task automatic drain_and_write(logic [31:0] g);
    wait (pending_pairs.size() == 0 && !start);
    @(posedge clk);
    while (expected_forces.size() > 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    grav_model = g;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    in_t p;
    logic [31:0] settings[6];
    settings = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001, 32'h0100_0000,
                 32'h0010_0000, 32'h0000_0000};
    settings[5] = $urandom;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    p = '0;
    queue_pair(p);
    p.this_pos_x = 32'h0001_0000;
    p.this_mass = 1; p.other_mass = 1;
    queue_pair(p);
    p.this_pos_x = 32'h8000_0000; p.other_pos_x = 32'h7FFF_FFFF;
    p.this_pos_y = 32'h8000_0000; p.other_pos_y = 32'h7FFF_FFFF;
    p.this_pos_z = 32'h7FFF_FFFF; p.other_pos_z = 32'h8000_0000;
    p.this_mass = '1; p.other_mass = '1;
    queue_pair(p);
    p = '0; p.this_pos_z = 1; p.this_mass = '1; p.other_mass = '1;
    queue_pair(p);
    p = '0; p.other_pos_y = 1; p.this_mass = 5; p.other_mass = 7;
    queue_pair(p);
    p = '0; p.this_pos_x = 32'h0003_0000; p.this_pos_y = 32'h0004_0000;
    p.this_mass = 100; p.other_mass = 0;
    queue_pair(p);
    p.other_mass = 100;
    queue_pair(p);
    p = '0; p.this_pos_x = 32'h1234_5678; p.other_pos_x = 32'h1234_5678;
    p.this_mass = '1; p.other_mass = '1;
    queue_pair(p);
    p.this_pos_y = 32'hFFFF_FFFF;
    queue_pair(p);
    for (int i = 0; i < 6; i++) queue_pair(rand_pair());

    drain_and_write(settings[0]);
    for (int i = 0; i < 10; i++) queue_pair(rand_pair());
    p = '0; p.this_pos_x = 1; p.this_mass = '1; p.other_mass = '1;
    queue_pair(p);

    for (int ph = 1; ph < 6; ph++) begin
      drain_and_write(settings[ph]);
      for (int i = 0; i < NumRandom / 5; i++) queue_pair(rand_pair());
      if (ph == 3) begin
        wait (pending_pairs.size() < NumRandom / 10);
        hold_sender = 1'b1;
        @(posedge clk);
        wait (expected_forces.size() == 0 && !start);
        hold_sender = 1'b0;
      end
      if (ph == 5) begin
        wait (pending_pairs.size() < NumRandom / 10);
        gaps_on = 1'b0;
      end
    end

    wait (pending_pairs.size() == 0 && !start);
    while (expected_forces.size() > 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("sent %0d body pairs, checked %0d results", pairs_sent, results_seen);
    $display("G values: full scale, zero, one lsb, unity, small, random");
    if (mismatches == 0 && expected_forces.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/pgf_pkg.sv
rtl/pgf_front.sv
rtl/pgf_sqrt.sv
rtl/pgf_prep.sv
rtl/pgf_divide.sv
rtl/pairwise_gravity_force_unit.sv
dv/pairwise_gravity_force_unit_tb.sv
